// ===== src/lsi_pkg.sv =====
// Shared constants and types for the line and sphere intersection pipeline.
package lsi_pkg;

   // Width of one multiplier operand slice in the pipelined multipliers.
   localparam int MUL_CHUNK = 16;

   typedef logic [1:0] count_type;

   localparam count_type HIT_NONE = 2'd0;
   localparam count_type HIT_ONE  = 2'd1;
   localparam count_type HIT_TWO  = 2'd2;

endpackage

// ===== src/lsi_mul.sv =====
// Pipelined signed multiplier that adds one operand slice per stage.
module lsi_mul #(
   parameter int AW = 70,
   parameter int BW = 33,
   parameter int TW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [TW-1:0]        in_tag,
   input  logic signed [AW-1:0] in_a,
   input  logic signed [BW-1:0] in_b,
   output logic                 out_valid,
   output logic [TW-1:0]        out_tag,
   output logic signed [AW+BW-1:0] out_p
);
   import lsi_pkg::*;

   localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int BPW = NCH * MUL_CHUNK;
   localparam int ACW = AW + BPW;
   localparam int PW  = AW + BW;

   logic            vld_ff [NCH+1];
   logic [TW-1:0]   tag_ff [NCH+1];
   logic            neg_ff [NCH+1];
   logic [AW-1:0]   am_ff  [NCH+1];
   logic [BPW-1:0]  bm_ff  [NCH+1];
   logic [ACW-1:0]  acc_ff [NCH+1];

   logic                 fvld_ff;
   logic [TW-1:0]        ftag_ff;
   logic signed [PW-1:0] p_ff;

   logic [AW-1:0] am_in;
   logic [BW-1:0] bm_in;

   // Operands go through as magnitudes; the sign is put back at the end.
   always_comb begin
      am_in = in_a[AW-1] ? AW'(-in_a) : AW'(in_a);
      bm_in = in_b[BW-1] ? BW'(-in_b) : BW'(in_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      tag_ff[0] <= in_tag;
      neg_ff[0] <= in_a[AW-1] ^ in_b[BW-1];
      am_ff[0]  <= am_in;
      bm_ff[0]  <= BPW'(bm_in);
      acc_ff[0] <= '0;
   end

   for (genvar k = 1; k <= NCH; k++) begin : g_stage
      logic [AW+MUL_CHUNK-1:0] pp;

      assign pp = (AW+MUL_CHUNK)'(am_ff[k-1])
                * (AW+MUL_CHUNK)'(bm_ff[k-1][(k-1)*MUL_CHUNK +: MUL_CHUNK]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         tag_ff[k] <= tag_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         am_ff[k]  <= am_ff[k-1];
         bm_ff[k]  <= bm_ff[k-1];
         acc_ff[k] <= acc_ff[k-1] + (ACW'(pp) << ((k-1) * MUL_CHUNK));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvld_ff <= 1'b0;
      end else begin
         fvld_ff <= vld_ff[NCH];
      end
      ftag_ff <= tag_ff[NCH];
      p_ff    <= neg_ff[NCH] ? PW'(-acc_ff[NCH]) : PW'(acc_ff[NCH]);
   end

   assign out_valid = fvld_ff;
   assign out_tag   = ftag_ff;
   assign out_p     = p_ff;

endmodule

// ===== src/lsi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module lsi_sqrt #(
   parameter int NW = 136,
   parameter int TW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [TW-1:0]         in_tag,
   input  logic [NW-1:0]         in_n,
   output logic                  out_valid,
   output logic [TW-1:0]         out_tag,
   output logic [(NW+1)/2-1:0]   out_root
);
   localparam int RW  = (NW + 1) / 2;
   localparam int PNW = 2 * RW;
   localparam int RMW = RW + 3;

   logic           vld_ff  [RW+1];
   logic [TW-1:0]  tag_ff  [RW+1];
   logic [PNW-1:0] rad_ff  [RW+1];
   logic [RMW-1:0] rem_ff  [RW+1];
   logic [RW-1:0]  root_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      tag_ff[0]  <= in_tag;
      rad_ff[0]  <= PNW'(in_n);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar k = 1; k <= RW; k++) begin : g_stage
      logic [RMW-1:0] rem_t;
      logic [RMW-1:0] trial;
      logic           ge;

      // The remainder never exceeds twice the partial root, so its top bits are free.
      assign rem_t = {rem_ff[k-1][RMW-3:0], rad_ff[k-1][PNW-1:PNW-2]};
      assign trial = RMW'({root_ff[k-1], 2'b01});
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         tag_ff[k]  <= tag_ff[k-1];
         rad_ff[k]  <= rad_ff[k-1] << 2;
         rem_ff[k]  <= ge ? rem_t - trial : rem_t;
         root_ff[k] <= {root_ff[k-1][RW-2:0], ge};
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_tag   = tag_ff[RW];
   assign out_root  = root_ff[RW];

endmodule

// ===== src/lsi_div.sv =====
// Pipelined rounding divider with a quotient clamped to QW bits.
module lsi_div #(
   parameter int NW  = 103,
   parameter int DNW = 67,
   parameter int QW  = 32,
   parameter int TW  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [TW-1:0]        in_tag,
   input  logic signed [NW-1:0] in_num,
   input  logic [DNW-1:0]       in_den,
   output logic                 out_valid,
   output logic [TW-1:0]        out_tag,
   output logic [QW-1:0]        out_mag,
   output logic                 out_neg
);
   localparam int N2W = NW + 2;
   localparam int D2W = DNW + 1;
   localparam int HW  = N2W - QW;
   localparam int XW  = (HW > D2W) ? HW : D2W;
   localparam int RMW = DNW + 2;

   logic            p0_vld_ff;
   logic [TW-1:0]   p0_tag_ff;
   logic            p0_neg_ff;
   logic [N2W-1:0]  p0_n2_ff;
   logic [D2W-1:0]  p0_d2_ff;

   logic            vld_ff [QW+1];
   logic [TW-1:0]   tag_ff [QW+1];
   logic            neg_ff [QW+1];
   logic            ovf_ff [QW+1];
   logic [D2W-1:0]  d2_ff  [QW+1];
   logic [QW-1:0]   lo_ff  [QW+1];
   logic [RMW-1:0]  rem_ff [QW+1];
   logic [QW-1:0]   q_ff   [QW+1];

   logic [NW-1:0] mag_in;
   logic [XW-1:0] hi_in;
   logic          ovf_in;

   always_comb begin
      mag_in = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
      hi_in  = XW'(p0_n2_ff[N2W-1:QW]);
      ovf_in = hi_in >= XW'(p0_d2_ff);
   end

   // Rounding to nearest is (2|n| + d) / (2d) on magnitudes.
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
      end else begin
         p0_vld_ff <= in_valid;
      end
      p0_tag_ff <= in_tag;
      p0_neg_ff <= in_num[NW-1];
      p0_n2_ff  <= N2W'({mag_in, 1'b0}) + N2W'(in_den);
      p0_d2_ff  <= {in_den, 1'b0};
   end

   // A quotient too wide for QW bits is flagged here and clamped at the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= p0_vld_ff;
      end
      tag_ff[0] <= p0_tag_ff;
      neg_ff[0] <= p0_neg_ff;
      ovf_ff[0] <= ovf_in;
      d2_ff[0]  <= p0_d2_ff;
      lo_ff[0]  <= p0_n2_ff[QW-1:0];
      rem_ff[0] <= ovf_in ? '0 : RMW'(hi_in);
      q_ff[0]   <= '0;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [RMW-1:0] rem_t;
      logic           ge;

      assign rem_t = {rem_ff[k-1][RMW-2:0], lo_ff[k-1][QW-1]};
      assign ge    = rem_t >= RMW'(d2_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         tag_ff[k] <= tag_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         d2_ff[k]  <= d2_ff[k-1];
         lo_ff[k]  <= lo_ff[k-1] << 1;
         rem_ff[k] <= ge ? rem_t - RMW'(d2_ff[k-1]) : rem_t;
         q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_tag   = tag_ff[QW];
   assign out_mag   = ovf_ff[QW] ? '1 : q_ff[QW];
   assign out_neg   = neg_ff[QW];

endmodule

// ===== src/line_sphere_intersect.sv =====
// Top level of the line and sphere intersection pipeline.
//
//   channel   ports                    handshake
//   request   req_*, start, busy       beat taken when start is high and busy is low
//   response  rsp_*, rsp_valid         beat lasts one cycle, cannot be held off
//
// One beat enters every cycle; busy stays low. The latency is set mostly
// by the one-bit-per-stage square root and divider. Reset clears only the
// valid bits of the pipeline. The receiver cannot stall, so the pipeline
// never holds.
module line_sphere_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0]        req_radius,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   output logic                          rsp_valid,
   output lsi_pkg::count_type            rsp_hit_count,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_a_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_a_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_a_z,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_b_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_b_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_b_z
);
   import lsi_pkg::*;

   // The fraction bits cancel in the math; they only name the binary point.
   localparam int CW   = COORD_WIDTH;
   localparam int DW1  = CW + 1;
   localparam int PW1  = 2 * DW1;
   localparam int RRW  = 2 * (CW - 1);
   localparam int ABW  = PW1 + 2;
   localparam int DSW  = 2 * ABW + 1;
   localparam int SNW  = DSW - 1;
   localparam int RW   = (SNW + 1) / 2;
   localparam int NUMW = ABW + 2;
   localparam int PW2  = NUMW + DW1;
   localparam int SW   = CW + 2;

   localparam int NCH1 = (ABW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NCH2 = (DW1 + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int LAT  = 4 + (NCH1 + 2) + 1 + (RW + 1) + 1 + (NCH2 + 2) + (CW + 2) + 1;

   typedef struct packed {
      logic [ABW-2:0]         a;
      logic [ABW-1:0]         b;
      logic [2:0][CW-1:0]     p1;
      logic [2:0][DW1-1:0]    d;
      logic                   dneg;
      logic                   degen;
   } tag1_type;

   typedef struct packed {
      count_type              cnt;
      logic [ABW-2:0]         a;
      logic [ABW-1:0]         b;
      logic [2:0][CW-1:0]     p1;
      logic [2:0][DW1-1:0]    d;
      logic                   dneg;
   } tag2_type;

   typedef struct packed {
      count_type              cnt;
      logic [ABW-2:0]         a;
      logic [2:0][CW-1:0]     p1;
   } tag3_type;

   typedef struct packed {
      count_type              cnt;
      logic [2:0][CW-1:0]     p1;
   } tag4_type;

   logic accept;

   // Stage 1: request registers.
   logic                 v1_ff;
   logic signed [CW-1:0] cen1_ff [3];
   logic signed [CW-1:0] p11_ff  [3];
   logic signed [CW-1:0] p21_ff  [3];
   logic [CW-2:0]        rad1_ff;

   // Stage 2: direction and offset.
   logic                  v2_ff;
   logic signed [DW1-1:0] d2_ff  [3];
   logic signed [DW1-1:0] w2_ff  [3];
   logic signed [CW-1:0]  p12_ff [3];
   logic [CW-2:0]         rad2_ff;
   logic                  dneg2_ff;
   logic                  degen2_ff;
   logic                  dneg_in;
   logic                  degen_in;

   // Stage 3: products.
   logic                  v3_ff;
   logic signed [PW1-1:0] dd3_ff [3];
   logic signed [PW1-1:0] wd3_ff [3];
   logic signed [PW1-1:0] ww3_ff [3];
   logic [RRW-1:0]        rr3_ff;
   logic signed [DW1-1:0] d3_ff  [3];
   logic signed [CW-1:0]  p13_ff [3];
   logic                  dneg3_ff;
   logic                  degen3_ff;

   // Stage 4: quadratic coefficients.
   logic                  v4_ff;
   logic signed [ABW-1:0] a4_ff;
   logic signed [ABW-1:0] b4_ff;
   logic signed [ABW-1:0] c4_ff;
   logic [2:0][CW-1:0]    p14_ff;
   logic [2:0][DW1-1:0]   d4_ff;
   logic                  dneg4_ff;
   logic                  degen4_ff;

   logic                      bb_valid;
   tag1_type                  bb_tag;
   logic signed [2*ABW-1:0]   bb_p;
   logic signed [2*ABW-1:0]   ac_p;

   // Stage 5: discriminant.
   logic                  v5_ff;
   logic signed [DSW-1:0] disc5_ff;
   tag1_type              t5_ff;
   tag2_type              tag2_in;
   logic [SNW-1:0]        sq_n;

   logic                  sq_valid;
   tag2_type              sq_tag;
   logic [RW-1:0]         sq_root;

   // Stage 6: root numerators.
   logic                   v6_ff;
   logic signed [NUMW-1:0] num6_ff [2];
   logic signed [DW1-1:0]  d6_ff   [3];
   tag3_type               t6_ff;
   logic signed [NUMW-1:0] sn_in;
   logic signed [NUMW-1:0] nb_in;

   logic                   ml_valid;
   tag3_type               ml_tag;
   logic signed [PW2-1:0]  ml_p [6];

   logic                   dv_valid;
   tag4_type               dv_tag;
   tag4_type               tag4_in;
   logic [CW-1:0]          dv_mag [6];
   logic                   dv_neg [6];

   // Output registers.
   logic                 rv_ff;
   count_type            cnt_ff;
   logic signed [CW-1:0] hit_ff [6];
   logic signed [CW-1:0] hit_in [6];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      cen1_ff[0] <= req_center_x;
      cen1_ff[1] <= req_center_y;
      cen1_ff[2] <= req_center_z;
      p11_ff[0]  <= req_first_x;
      p11_ff[1]  <= req_first_y;
      p11_ff[2]  <= req_first_z;
      p21_ff[0]  <= req_second_x;
      p21_ff[1]  <= req_second_y;
      p21_ff[2]  <= req_second_z;
      rad1_ff    <= req_radius;
   end

   // The principal axis is the first one on which the two points differ.
   always_comb begin
      degen_in = 1'b1;
      dneg_in  = 1'b0;
      for (int k = 2; k >= 0; k--) begin
         if (p11_ff[k] != p21_ff[k]) begin
            degen_in = 1'b0;
            dneg_in  = p21_ff[k] < p11_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      for (int k = 0; k < 3; k++) begin
         d2_ff[k]  <= DW1'(p21_ff[k]) - DW1'(p11_ff[k]);
         w2_ff[k]  <= DW1'(p11_ff[k]) - DW1'(cen1_ff[k]);
         p12_ff[k] <= p11_ff[k];
      end
      rad2_ff   <= rad1_ff;
      dneg2_ff  <= dneg_in;
      degen2_ff <= degen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      for (int k = 0; k < 3; k++) begin
         dd3_ff[k] <= PW1'(d2_ff[k]) * PW1'(d2_ff[k]);
         wd3_ff[k] <= PW1'(w2_ff[k]) * PW1'(d2_ff[k]);
         ww3_ff[k] <= PW1'(w2_ff[k]) * PW1'(w2_ff[k]);
         d3_ff[k]  <= d2_ff[k];
         p13_ff[k] <= p12_ff[k];
      end
      rr3_ff    <= RRW'(rad2_ff) * RRW'(rad2_ff);
      dneg3_ff  <= dneg2_ff;
      degen3_ff <= degen2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      a4_ff <= ABW'(dd3_ff[0]) + ABW'(dd3_ff[1]) + ABW'(dd3_ff[2]);
      b4_ff <= ABW'(wd3_ff[0]) + ABW'(wd3_ff[1]) + ABW'(wd3_ff[2]);
      c4_ff <= ABW'(ww3_ff[0]) + ABW'(ww3_ff[1]) + ABW'(ww3_ff[2])
             - $signed(ABW'(rr3_ff));
      for (int k = 0; k < 3; k++) begin
         p14_ff[k] <= p13_ff[k];
         d4_ff[k]  <= d3_ff[k];
      end
      dneg4_ff  <= dneg3_ff;
      degen4_ff <= degen3_ff;
   end

   tag1_type tag1_full;

   always_comb begin
      tag1_full.a     = a4_ff[ABW-2:0];
      tag1_full.b     = b4_ff;
      tag1_full.p1    = p14_ff;
      tag1_full.d     = d4_ff;
      tag1_full.dneg  = dneg4_ff;
      tag1_full.degen = degen4_ff;
   end

   lsi_mul #(.AW(ABW), .BW(ABW), .TW($bits(tag1_type))) u_mul_bb (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_tag    (tag1_full),
      .in_a      (b4_ff),
      .in_b      (b4_ff),
      .out_valid (bb_valid),
      .out_tag   (bb_tag),
      .out_p     (bb_p)
   );

   lsi_mul #(.AW(ABW), .BW(ABW), .TW(1)) u_mul_ac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_tag    (1'b0),
      .in_a      (a4_ff),
      .in_b      (c4_ff),
      .out_valid (),
      .out_tag   (),
      .out_p     (ac_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= bb_valid;
      end
      disc5_ff <= DSW'(bb_p) - DSW'(ac_p);
      t5_ff    <= bb_tag;
   end

   always_comb begin
      tag2_in.a    = t5_ff.a;
      tag2_in.b    = t5_ff.b;
      tag2_in.p1   = t5_ff.p1;
      tag2_in.d    = t5_ff.d;
      tag2_in.dneg = t5_ff.dneg;
      if (t5_ff.degen || disc5_ff[DSW-1]) begin
         tag2_in.cnt = HIT_NONE;
      end else if (disc5_ff == '0) begin
         tag2_in.cnt = HIT_ONE;
      end else begin
         tag2_in.cnt = HIT_TWO;
      end
      sq_n = disc5_ff[DSW-1] ? '0 : disc5_ff[DSW-2:0];
   end

   lsi_sqrt #(.NW(SNW), .TW($bits(tag2_type))) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_tag    (tag2_in),
      .in_n      (sq_n),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .out_root  (sq_root)
   );

   // The first hit takes the root that grows along the principal axis.
   always_comb begin
      sn_in = NUMW'($signed({1'b0, sq_root}));
      if (sq_tag.dneg) begin
         sn_in = -sn_in;
      end
      nb_in = -NUMW'($signed(sq_tag.b));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= sq_valid;
      end
      num6_ff[0] <= nb_in + sn_in;
      num6_ff[1] <= nb_in - sn_in;
      for (int k = 0; k < 3; k++) begin
         d6_ff[k] <= $signed(sq_tag.d[k]);
      end
      t6_ff.cnt <= sq_tag.cnt;
      t6_ff.a   <= sq_tag.a;
      t6_ff.p1  <= sq_tag.p1;
   end

   always_comb begin
      tag4_in.cnt = ml_tag.cnt;
      tag4_in.p1  = ml_tag.p1;
   end

   for (genvar j = 0; j < 2; j++) begin : g_root
      for (genvar k = 0; k < 3; k++) begin : g_axis
         localparam int L = 3 * j + k;

         if (L == 0) begin : g_lead
            lsi_mul #(.AW(NUMW), .BW(DW1), .TW($bits(tag3_type))) u_mul (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (v6_ff),
               .in_tag    (t6_ff),
               .in_a      (num6_ff[j]),
               .in_b      (d6_ff[k]),
               .out_valid (ml_valid),
               .out_tag   (ml_tag),
               .out_p     (ml_p[L])
            );

            lsi_div #(.NW(PW2), .DNW(ABW-1), .QW(CW), .TW($bits(tag4_type))) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (ml_valid),
               .in_tag    (tag4_in),
               .in_num    (ml_p[L]),
               .in_den    (ml_tag.a),
               .out_valid (dv_valid),
               .out_tag   (dv_tag),
               .out_mag   (dv_mag[L]),
               .out_neg   (dv_neg[L])
            );
         end else begin : g_lane
            lsi_mul #(.AW(NUMW), .BW(DW1), .TW(1)) u_mul (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (v6_ff),
               .in_tag    (1'b0),
               .in_a      (num6_ff[j]),
               .in_b      (d6_ff[k]),
               .out_valid (),
               .out_tag   (),
               .out_p     (ml_p[L])
            );

            lsi_div #(.NW(PW2), .DNW(ABW-1), .QW(CW), .TW(1)) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (ml_valid),
               .in_tag    (1'b0),
               .in_num    (ml_p[L]),
               .in_den    (ml_tag.a),
               .out_valid (),
               .out_tag   (),
               .out_mag   (dv_mag[L]),
               .out_neg   (dv_neg[L])
            );
         end
      end
   end

   // A clamped quotient still lands on the right limit after the saturation.
   always_comb begin
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] qs;
      logic signed [SW-1:0] smax;
      logic signed [SW-1:0] smin;
      logic                 keep;
      smax = $signed({3'b000, {(CW-1){1'b1}}});
      smin = $signed({3'b111, {(CW-1){1'b0}}});
      for (int j = 0; j < 2; j++) begin
         for (int k = 0; k < 3; k++) begin
            qs  = $signed(SW'(dv_mag[3*j+k]));
            sum = SW'($signed(dv_tag.p1[k])) + (dv_neg[3*j+k] ? -qs : qs);
            if (j == 0) begin
               keep = dv_tag.cnt != HIT_NONE;
            end else begin
               keep = dv_tag.cnt == HIT_TWO;
            end
            if (!keep) begin
               hit_in[3*j+k] = '0;
            end else if (sum > smax) begin
               hit_in[3*j+k] = smax[CW-1:0];
            end else if (sum < smin) begin
               hit_in[3*j+k] = smin[CW-1:0];
            end else begin
               hit_in[3*j+k] = sum[CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dv_valid;
      end
      cnt_ff <= dv_tag.cnt;
      for (int l = 0; l < 6; l++) begin
         hit_ff[l] <= hit_in[l];
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_hit_count = cnt_ff;
   assign rsp_hit_a_x   = hit_ff[0];
   assign rsp_hit_a_y   = hit_ff[1];
   assign rsp_hit_a_z   = hit_ff[2];
   assign rsp_hit_b_x   = hit_ff[3];
   assign rsp_hit_b_y   = hit_ff[4];
   assign rsp_hit_b_z   = hit_ff[5];

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted beat did not come out after the pipeline latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##LAT !rsp_valid)
      else $error("response beat without a matching request");

   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_count == HIT_NONE || rsp_hit_count == HIT_ONE
                     || rsp_hit_count == HIT_TWO))
      else $error("hit count out of range");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_count != HIT_TWO) |->
         (rsp_hit_b_x == '0 && rsp_hit_b_y == '0 && rsp_hit_b_z == '0))
      else $error("second hit not cleared");
`endif

endmodule
